// File: rtl/box_ds_pkg.sv
// Package with constants, payload types and control structs of the 2x2 box downscaler.
package box_ds_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

  localparam int CFG_W  = 13;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int IDX_W  = $clog2(LINE_DEPTH);
  localparam int WID_W  = COL_W + 1;
  localparam int HGT_W  = ROW_W + 1;
  localparam int CH_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            row_end;
    logic            frame_end;
  } out_item_t;

  typedef struct packed {
    logic             hold;
    logic             wr;
    logic             rd;
    logic [IDX_W-1:0] idx;
  } lane_ctl_t;

  typedef struct packed {
    logic valid;
    logic row_end;
    logic frame_end;
  } stage_t;

endpackage

// File: rtl/box_ds_lane.sv
// One color lane: left pixel hold, pair sum, line store slice and block average.
module box_ds_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  box_ds_pkg::lane_ctl_t       ctl_i,
  input  logic [box_ds_pkg::CH_W-1:0] pix_i,
  output logic [box_ds_pkg::CH_W-1:0] avg_o
);
  import box_ds_pkg::*;

  logic [CH_W-1:0] hold_q;
  logic [CH_W:0]   pair;
  logic [CH_W:0]   pair_q;
  logic [CH_W:0]   above_q;
  logic [CH_W+1:0] sum;
  logic [CH_W:0]   line_mem [LINE_DEPTH];

  assign pair = {1'b0, hold_q} + {1'b0, pix_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else if (ctl_i.hold) begin
      hold_q <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      line_mem[ctl_i.idx] <= pair;
    end
    if (ctl_i.rd) begin
      above_q <= line_mem[ctl_i.idx];
      pair_q  <= pair;
    end
  end

  assign sum   = {1'b0, pair_q} + {1'b0, above_q};
  assign avg_o = sum[CH_W+1:2];

endmodule

// File: rtl/box_ds_ctrl.sv
// Size registers, raster counters and lane control for the 2x2 box downscaler.
module box_ds_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [box_ds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [box_ds_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                             acc_i,
  input  logic                             adv_i,
  output box_ds_pkg::lane_ctl_t            lane_ctl_o,
  output box_ds_pkg::stage_t               stage_o
);
  import box_ds_pkg::*;

  logic [CFG_W-1:0] width_cfg_q, height_cfg_q;
  logic [WID_W-1:0] w;
  logic [HGT_W-1:0] h;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             emit;
  logic             rend, fend;
  logic [COL_W-1:0] idx_next;
  logic [ROW_W-1:0] rpair_next;
  stage_t           stage_q, stage_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= WIDTH_RESET;
      height_cfg_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_cfg_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_cfg_q == '0) begin
      w = WID_W'(1);
    end else if (int'(width_cfg_q) > MAX_WIDTH) begin
      w = WID_W'(MAX_WIDTH);
    end else begin
      w = WID_W'(width_cfg_q);
    end
    if (height_cfg_q == '0) begin
      h = HGT_W'(1);
    end else if (int'(height_cfg_q) > MAX_HEIGHT) begin
      h = HGT_W'(MAX_HEIGHT);
    end else begin
      h = HGT_W'(height_cfg_q);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc_i) begin
      if ({1'b0, col_q} + WID_W'(1) >= w) begin
        col_d = '0;
        if ({1'b0, row_q} + HGT_W'(1) >= h) begin
          row_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign idx_next   = {1'b0, col_q[COL_W-1:1]} + COL_W'(1);
  assign rpair_next = {1'b0, row_q[ROW_W-1:1]} + ROW_W'(1);
  assign rend       = (idx_next == w[WID_W-1:1]);
  assign fend       = rend && (rpair_next == h[HGT_W-1:1]);
  assign emit       = col_q[0] && row_q[0];

  assign lane_ctl_o.hold = acc_i && !col_q[0];
  assign lane_ctl_o.wr   = acc_i && col_q[0] && !row_q[0];
  assign lane_ctl_o.rd   = acc_i && emit;
  assign lane_ctl_o.idx  = col_q[COL_W-1:1];

  always_comb begin
    stage_d = stage_q;
    if (adv_i) begin
      stage_d.valid     = acc_i && emit;
      stage_d.row_end   = rend;
      stage_d.frame_end = fend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

  a_emit_on_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stage_q.valid) |-> $past(col_q[0]) && $past(row_q[0]))
    else $error("stage loaded from an even row or column");

  a_write_read_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lane_ctl_o.wr && lane_ctl_o.rd))
    else $error("line store written and read in the same cycle");

  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q.valid && stage_q.frame_end |-> stage_q.row_end)
    else $error("frame end without row end");

endmodule

// File: rtl/box_downscale_2x2_top.sv
// Top level of the 2x2 box downscaler: three color lanes, control and output register.
//
// Pixels enter on the in channel in raster order, one item per pixel, and
// leave on the out channel as one item per 2x2 block, emitted after the
// second pixel of each pair on odd rows. Each channel is the truncated
// average of the block; row_end and frame_end mark the last item of an
// output row and of the frame. An odd last column or row gives no item.
// The image size is written through the configuration port while the block
// is idle; a size of zero acts as one and a size above 4096 saturates.
// The accepting edge loads the stage register, and the output register takes
// the item from it once it may advance; the item then shows on the out
// channel. Throughput is one pixel per clock while the receiver does not stall;
// each lane's line store slice sees one access per pixel pair on its single port.
// Reset sets the size to 640 by 480 and clears the counters; the line store
// is not cleared and needs no clearing pass as long as the width is not raised
// during an odd row, since an even row then fills an entry before the odd row below reads it.
// When the output register holds an item and the receiver stalls, the whole
// pipeline freezes and in_stall_o is raised in the same cycle.
module box_downscale_2x2_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [box_ds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [box_ds_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  box_ds_pkg::in_item_t             in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output box_ds_pkg::out_item_t            out_item_o
);
  import box_ds_pkg::*;

  logic      adv;
  logic      acc;
  lane_ctl_t lane_ctl;
  stage_t    stage;
  logic [CH_W-1:0] avg_r, avg_g, avg_b;
  logic      out_valid_q;
  out_item_t out_item_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign acc        = in_valid_i && adv;
  assign in_stall_o = !adv;

  box_ds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .adv_i      (adv),
    .lane_ctl_o (lane_ctl),
    .stage_o    (stage)
  );

  box_ds_lane u_lane_r (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (lane_ctl),
    .pix_i (in_item_i.red_in), .avg_o (avg_r)
  );

  box_ds_lane u_lane_g (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (lane_ctl),
    .pix_i (in_item_i.green_in), .avg_o (avg_g)
  );

  box_ds_lane u_lane_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (lane_ctl),
    .pix_i (in_item_i.blue_in), .avg_o (avg_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= stage.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && stage.valid) begin
      out_item_q.red_out   <= avg_r;
      out_item_q.green_out <= avg_g;
      out_item_q.blue_out  <= avg_b;
      out_item_q.row_end   <= stage.row_end;
      out_item_q.frame_end <= stage.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output register can move");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(stage.valid))
    else $error("output item without a loaded stage");

  a_out_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_end |-> out_item_o.row_end)
    else $error("frame end item is not a row end item");

endmodule

// File: test/tb_box_downscale_2x2_top.sv
// Testbench for the 2x2 box downscaler: predicts every averaged block and checks it on output.
`timescale 1ns / 100ps

module tb_box_downscale_2x2_top;
  import box_ds_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_TOTAL = 1400;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } pair_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  in_item_t pixel_queue[$];
  out_item_t expected_blocks[$];

  logic [CFG_W-1:0] width_reg = WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  in_item_t left_px = '0;
  pair_sum_t pair_sums[LINE_DEPTH];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned random_pixels = 0;
  int unsigned blocks_checked = 0;
  int unsigned row_ends = 0;
  int unsigned frame_ends = 0;
  int unsigned cycles = 0;

  box_downscale_2x2_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_size(logic [CFG_W-1:0] value, int unsigned maxv);
    if (value == '0) return 1;
    if (32'(value) > maxv) return maxv;
    return 32'(value);
  endfunction

  function automatic void downscale_pixel(in_item_t px);
    int unsigned w;
    int unsigned h;
    int unsigned slot;
    pair_sum_t pair;
    pair_sum_t above;
    logic [9:0] sum_r;
    logic [9:0] sum_g;
    logic [9:0] sum_b;
    out_item_t blk;
    w = eff_size(width_reg, MAX_WIDTH);
    h = eff_size(height_reg, MAX_HEIGHT);
    if (col_pos % 2 == 0) begin
      left_px = px;
    end else begin
      pair.red = {1'b0, left_px.red_in} + {1'b0, px.red_in};
      pair.green = {1'b0, left_px.green_in} + {1'b0, px.green_in};
      pair.blue = {1'b0, left_px.blue_in} + {1'b0, px.blue_in};
      slot = col_pos / 2;
      if (row_pos % 2 == 0) begin
        pair_sums[slot] = pair;
      end else begin
        above = pair_sums[slot];
        sum_r = {1'b0, pair.red} + {1'b0, above.red};
        sum_g = {1'b0, pair.green} + {1'b0, above.green};
        sum_b = {1'b0, pair.blue} + {1'b0, above.blue};
        blk.red_out = sum_r[9:2];
        blk.green_out = sum_g[9:2];
        blk.blue_out = sum_b[9:2];
        blk.row_end = (slot + 1 == w / 2);
        blk.frame_end = blk.row_end && (row_pos / 2 + 1 == h / 2);
        expected_blocks.push_back(blk);
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 20) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    end
  endtask

  task automatic check_block(out_item_t got);
    out_item_t want;
    if (expected_blocks.size() == 0) begin
      errors++;
      if (errors <= 20) begin
        $display("%0t ns: unexpected block, expected none, actual %h", $time, got);
      end
    end else begin
      want = expected_blocks.pop_front();
      check_field("red_out", 32'(want.red_out), 32'(got.red_out));
      check_field("green_out", 32'(want.green_out), 32'(got.green_out));
      check_field("blue_out", 32'(want.blue_out), 32'(got.blue_out));
      check_field("row_end", 32'(want.row_end), 32'(got.row_end));
      check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
      blocks_checked++;
      if (got.row_end) row_ends++;
      if (got.frame_end) frame_ends++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        downscale_pixel(in_item);
        pixels_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_item <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_block(out_item);
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d pixels queued and %0d blocks outstanding.",
               CYCLE_LIMIT, pixel_queue.size(), expected_blocks.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || in_valid || expected_blocks.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    if (idx == REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    in_item_t px;
    px.red_in = r;
    px.green_in = g;
    px.blue_in = b;
    pixel_queue.push_back(px);
  endtask

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_random_pixels(int unsigned count);
    repeat (count) push_pixel(rand_channel(), rand_channel(), rand_channel());
    random_pixels += count;
  endtask

  // A 1x1 frame wraps both counters on the next pixel, so the next pixel
  // lands at the top left corner whatever the position was.
  task automatic rewind_frame();
    write_size(REG_IMAGE_WIDTH, 13'd1);
    write_size(REG_IMAGE_HEIGHT, 13'd1);
    push_random_pixels(1);
    wait_idle();
  endtask

  initial begin
    logic [CFG_W-1:0] new_w;
    logic [CFG_W-1:0] new_h;
    int unsigned w;
    int unsigned h;
    int unsigned count;
    int sel;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_gap_pct = 13;
    recv_stall_pct = 54;

    write_size(REG_IMAGE_WIDTH, 13'd4);
    write_size(REG_IMAGE_HEIGHT, 13'd4);
    @(negedge clk);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd1, 8'd255, 8'd3);
    push_pixel(8'd1, 8'd255, 8'd0);
    push_pixel(8'hAA, 8'h55, 8'hAA);
    push_pixel(8'h55, 8'hAA, 8'h55);
    push_pixel(8'd1, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd254, 8'd0);
    push_pixel(8'hAA, 8'h55, 8'hAA);
    push_pixel(8'h55, 8'hAA, 8'h55);
    wait_idle();

    write_size(REG_IMAGE_WIDTH, 13'd3);
    write_size(REG_IMAGE_HEIGHT, 13'd3);
    @(negedge clk);
    push_random_pixels(9);

    while (random_pixels < RANDOM_TOTAL) begin
      if (random_pixels >= 930) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end else if (random_pixels >= 465) begin
        send_gap_pct = 54;
        recv_stall_pct = 13;
      end
      wait_idle();
      case ($urandom_range(0, 39))
        0, 1: new_w = 13'd0;
        2, 3: new_w = 13'd1;
        4: new_w = CFG_W'($urandom_range(4097, 8191));
        5, 6, 7: new_w = CFG_W'($urandom_range(13, 64));
        default: new_w = CFG_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 19))
        0: new_h = 13'd0;
        1: new_h = 13'd1;
        2: new_h = CFG_W'($urandom_range(4097, 8191));
        default: new_h = CFG_W'($urandom_range(2, 8));
      endcase
      sel = $urandom_range(0, 3);
      if (sel != 1) begin
        // Widening during an odd row would read line entries that were never filled.
        if (row_pos % 2 == 1 && eff_size(new_w, MAX_WIDTH) > eff_size(width_reg, MAX_WIDTH)) begin
          rewind_frame();
        end
        write_size(REG_IMAGE_WIDTH, new_w);
      end
      if (sel != 0) write_size(REG_IMAGE_HEIGHT, new_h);
      w = eff_size(width_reg, MAX_WIDTH);
      h = eff_size(height_reg, MAX_HEIGHT);
      if (w <= 64 && h <= 8 && $urandom_range(0, 9) < 7) count = w * h * $urandom_range(1, 2);
      else count = $urandom_range(1, 40);
      if (count > RANDOM_TOTAL - random_pixels) count = RANDOM_TOTAL - random_pixels;
      @(negedge clk);
      push_random_pixels(count);
    end

    wait_idle();
    repeat (8) @(negedge clk);
    $display("Checked %0d blocks from %0d pixels, with %0d row ends and %0d frame ends.",
             blocks_checked, pixels_sent, row_ends, frame_ends);
    $display("Sizes ranged from zero and one up to saturated values, with partial frames.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
